>>> hdl/mclm_pkg.sv
package mclm_pkg;

   // table sizes
   localparam int MUTEX_SLOTS    = 16;
   localparam int CV_SLOTS       = 16;
   localparam int QUEUE_DEPTH    = 16;
   localparam int WAITERS_PER_CV = 16;

   // derived widths
   localparam int SW  = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
   localparam int CW  = (CV_SLOTS > 1) ? $clog2(CV_SLOTS) : 1;
   localparam int KW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int JW  = (WAITERS_PER_CV > 1) ? $clog2(WAITERS_PER_CV) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int WCW = $clog2(WAITERS_PER_CV + 1);
   localparam int FQ_DEPTH = MUTEX_SLOTS * QUEUE_DEPTH;
   localparam int FA_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int WT_DEPTH = CV_SLOTS * WAITERS_PER_CV;
   localparam int WA_W = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;

   // request commands
   localparam logic [2:0] CMD_LOCK   = 3'd0;
   localparam logic [2:0] CMD_UNLOCK = 3'd1;
   localparam logic [2:0] CMD_WAIT   = 3'd2;
   localparam logic [2:0] CMD_BCAST  = 3'd3;
   localparam logic [2:0] CMD_INTR   = 3'd4;
   localparam logic [2:0] CMD_TERM   = 3'd5;

   // reply codes
   localparam logic [2:0] RC_OK    = 3'd0;
   localparam logic [2:0] RC_PERM  = 3'd1;
   localparam logic [2:0] RC_INVAL = 3'd2;
   localparam logic [2:0] RC_INTR  = 3'd3;
   localparam logic [2:0] RC_FULL  = 3'd4;

   // datapath operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NOP          = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD         = 5'd1;
   localparam logic [OP_W-1:0] OP_LOCK         = 5'd2;
   localparam logic [OP_W-1:0] OP_EMIT_REQ     = 5'd3;
   localparam logic [OP_W-1:0] OP_EMIT_TGT     = 5'd4;
   localparam logic [OP_W-1:0] OP_SI_HIT       = 5'd5;
   localparam logic [OP_W-1:0] OP_SI_ZERO      = 5'd6;
   localparam logic [OP_W-1:0] OP_INC_SI       = 5'd7;
   localparam logic [OP_W-1:0] OP_RD_HEAD      = 5'd8;
   localparam logic [OP_W-1:0] OP_GRANT        = 5'd9;
   localparam logic [OP_W-1:0] OP_FREE_SLOT    = 5'd10;
   localparam logic [OP_W-1:0] OP_RD_NEXT      = 5'd11;
   localparam logic [OP_W-1:0] OP_WR_SHIFT     = 5'd12;
   localparam logic [OP_W-1:0] OP_DEC_BC       = 5'd13;
   localparam logic [OP_W-1:0] OP_K_ZERO       = 5'd14;
   localparam logic [OP_W-1:0] OP_RD_K         = 5'd15;
   localparam logic [OP_W-1:0] OP_INC_K        = 5'd16;
   localparam logic [OP_W-1:0] OP_MATCH        = 5'd17;
   localparam logic [OP_W-1:0] OP_WAIT_ADD     = 5'd18;
   localparam logic [OP_W-1:0] OP_CI_HIT       = 5'd19;
   localparam logic [OP_W-1:0] OP_CV_ZERO      = 5'd20;
   localparam logic [OP_W-1:0] OP_INC_CI       = 5'd21;
   localparam logic [OP_W-1:0] OP_J_ZERO       = 5'd22;
   localparam logic [OP_W-1:0] OP_RD_W         = 5'd23;
   localparam logic [OP_W-1:0] OP_INC_J        = 5'd24;
   localparam logic [OP_W-1:0] OP_CANCEL_CMP   = 5'd25;
   localparam logic [OP_W-1:0] OP_FREE_CV      = 5'd26;
   localparam logic [OP_W-1:0] OP_FREE_CV_DEAD = 5'd27;
   localparam logic [OP_W-1:0] OP_FLUSH        = 5'd28;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [2:0]      code;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       mk_hit;
      logic       mk_own;
      logic       ck_hit;
      logic       ck_full;
      logic       cv_free_any;
      logic       si_valid;
      logic       si_owner_tgt;
      logic       si_bc_zero;
      logic       si_last;
      logic       shift_more;
      logic       k_in;
      logic       rd_match;
      logic       ci_valid;
      logic       ci_last;
      logic       j_in;
      logic       j_live;
      logic       found;
      logic       can_emit;
      logic       hold_v;
      logic       out_free;
   } dp_stat_type;

   // blocked queue entry address
   function automatic logic [FA_W-1:0] fq_addr(input logic [SW-1:0] s, input logic [KW-1:0] k);
      return FA_W'(s) * FA_W'(QUEUE_DEPTH) + FA_W'(k);
   endfunction

   // waiter list entry address
   function automatic logic [WA_W-1:0] wt_addr(input logic [CW-1:0] c, input logic [JW-1:0] j);
      return WA_W'(c) * WA_W'(WAITERS_PER_CV) + WA_W'(j);
   endfunction

endpackage

>>> hdl/mclm_dpath.sv
module mclm_dpath import mclm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [95:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  dp_cmd_type  ctl,
   output dp_stat_type st,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   // captured request
   logic [2:0]  cmd_ff;
   logic [15:0] rq_ff, tgt_ff;
   logic [31:0] mk_ff, ck_ff;

   // mutex slot table
   logic [MUTEX_SLOTS-1:0] sv_ff;
   logic [31:0]            sk_ff [MUTEX_SLOTS];
   logic [15:0]            so_ff [MUTEX_SLOTS];
   logic [QCW-1:0]         bc_ff [MUTEX_SLOTS];

   // condition variable table
   logic [CV_SLOTS-1:0]                      cvv_ff;
   logic [31:0]                              cvk_ff [CV_SLOTS];
   logic [WCW-1:0]                           wc_ff [CV_SLOTS];
   logic [CV_SLOTS-1:0][WAITERS_PER_CV-1:0] wl_ff;

   // walk pointers
   logic [SW-1:0]  si_ff;
   logic [CW-1:0]  ci_ff;
   logic [QCW-1:0] k_ff, m_ff, mp1;
   logic [WCW-1:0] j_ff;
   logic           found_ff;

   // memories
   logic [15:0] fq_mem [FQ_DEPTH];
   logic [15:0] fq_rd_ff;
   logic [15:0] wp_mem [WT_DEPTH];
   logic [31:0] wm_mem [WT_DEPTH];
   logic [15:0] wp_rd_ff;
   logic [31:0] wm_rd_ff;

   // reply staging
   logic        hold_v_ff;
   logic [15:0] hold_dest_ff;
   logic [2:0]  hold_code_ff;
   logic        out_v_ff, out_last_ff;
   logic [15:0] out_dest_ff;
   logic [2:0]  out_code_ff;

   // slot search
   logic                   use_w;
   logic [15:0]            lk_proc;
   logic [31:0]            lk_key;
   logic [MUTEX_SLOTS-1:0] hit_vec;
   logic [SW-1:0]          hit_idx, free_idx;
   logic                   hit_any, free_any;
   logic [15:0]            hit_owner;
   logic [QCW-1:0]         hit_bc;
   logic                   lk_enq;

   // cv search
   logic [CV_SLOTS-1:0] cvh_vec;
   logic [CW-1:0]       cvh_idx, cvf_idx, wt_c;
   logic                cvh_any, cvf_any;
   logic [JW-1:0]       wt_j;

   // memory ports
   logic            fq_we, fq_re, wt_re;
   logic [FA_W-1:0] fq_wa, fq_ra;
   logic [15:0]     fq_wd;

   // reply path
   logic        emit_v, out_free, push, push_last;
   logic [15:0] emit_dest;
   logic [2:0]  emit_code;

   assign use_w   = (cmd_ff == CMD_BCAST);
   assign lk_proc = use_w ? wp_rd_ff : rq_ff;
   assign lk_key  = use_w ? wm_rd_ff : mk_ff;

   // parallel key compare over the slot table
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = MUTEX_SLOTS - 1; i >= 0; i--) begin
         hit_vec[i] = sv_ff[i] && (sk_ff[i] == lk_key);
         if (hit_vec[i]) hit_idx = SW'(i);
         if (!sv_ff[i]) free_idx = SW'(i);
      end
   end
   assign hit_any   = |hit_vec;
   assign free_any  = ~&sv_ff;
   assign hit_owner = so_ff[hit_idx];
   assign hit_bc    = bc_ff[hit_idx];
   assign lk_enq    = hit_any && (hit_owner != lk_proc) && (hit_bc < QCW'(QUEUE_DEPTH));

   // parallel key compare over the cv table
   always_comb begin
      cvh_idx = '0;
      cvf_idx = '0;
      for (int c = CV_SLOTS - 1; c >= 0; c--) begin
         cvh_vec[c] = cvv_ff[c] && (cvk_ff[c] == ck_ff);
         if (cvh_vec[c]) cvh_idx = CW'(c);
         if (!cvv_ff[c]) cvf_idx = CW'(c);
      end
   end
   assign cvh_any = |cvh_vec;
   assign cvf_any = ~&cvv_ff;
   assign wt_c    = cvh_any ? cvh_idx : cvf_idx;
   assign wt_j    = cvh_any ? wc_ff[cvh_idx][JW-1:0] : '0;
   assign mp1     = m_ff + QCW'(1);

   // reply generation
   always_comb begin
      emit_v    = 1'b0;
      emit_dest = rq_ff;
      emit_code = ctl.code;
      case (ctl.op)
         OP_LOCK: begin
            emit_dest = lk_proc;
            if (hit_any) begin
               emit_v    = !lk_enq;
               emit_code = (hit_owner == lk_proc) ? RC_PERM : RC_FULL;
            end else begin
               emit_v    = 1'b1;
               emit_code = free_any ? RC_OK : RC_FULL;
            end
         end
         OP_EMIT_REQ: emit_v = 1'b1;
         OP_EMIT_TGT: begin
            emit_v    = 1'b1;
            emit_dest = tgt_ff;
         end
         OP_GRANT: begin
            emit_v    = 1'b1;
            emit_dest = fq_rd_ff;
            emit_code = RC_OK;
         end
         default: emit_v = 1'b0;
      endcase
   end

   assign out_free  = !out_v_ff || rsp_tready;
   assign push      = hold_v_ff && (emit_v || (ctl.op == OP_FLUSH));
   assign push_last = (ctl.op == OP_FLUSH);

   // reply hold and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (push) begin
            out_v_ff    <= 1'b1;
            out_dest_ff <= hold_dest_ff;
            out_code_ff <= hold_code_ff;
            out_last_ff <= push_last;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
         if (emit_v) begin
            hold_v_ff    <= 1'b1;
            hold_dest_ff <= emit_dest;
            hold_code_ff <= emit_code;
         end else if (ctl.op == OP_FLUSH) begin
            hold_v_ff <= 1'b0;
         end
      end
   end

   // blocked queue memory ports
   always_comb begin
      fq_we = 1'b0;
      fq_wa = fq_addr(hit_idx, hit_bc[KW-1:0]);
      fq_wd = lk_proc;
      fq_re = 1'b0;
      fq_ra = fq_addr(si_ff, k_ff[KW-1:0]);
      case (ctl.op)
         OP_LOCK: fq_we = lk_enq;
         OP_WR_SHIFT: begin
            fq_we = 1'b1;
            fq_wa = fq_addr(si_ff, m_ff[KW-1:0]);
            fq_wd = fq_rd_ff;
         end
         OP_RD_HEAD: begin
            fq_re = 1'b1;
            fq_ra = fq_addr(si_ff, '0);
         end
         OP_RD_NEXT: begin
            fq_re = 1'b1;
            fq_ra = fq_addr(si_ff, mp1[KW-1:0]);
         end
         OP_RD_K: fq_re = 1'b1;
         default: fq_re = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fq_we) fq_mem[fq_wa] <= fq_wd;
      if (fq_re) fq_rd_ff <= fq_mem[fq_ra];
   end

   // waiter list memory
   assign wt_re = (ctl.op == OP_RD_W);
   always_ff @(posedge clock) begin
      if (ctl.op == OP_WAIT_ADD) begin
         wp_mem[wt_addr(wt_c, wt_j)] <= rq_ff;
         wm_mem[wt_addr(wt_c, wt_j)] <= mk_ff;
      end
      if (wt_re) begin
         wp_rd_ff <= wp_mem[wt_addr(ci_ff, j_ff[JW-1:0])];
         wm_rd_ff <= wm_mem[wt_addr(ci_ff, j_ff[JW-1:0])];
      end
   end

   // table and pointer updates
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff  <= '0;
         cvv_ff <= '0;
         wl_ff  <= '0;
         for (int i = 0; i < MUTEX_SLOTS; i++) bc_ff[i] <= '0;
         for (int c = 0; c < CV_SLOTS; c++) wc_ff[c] <= '0;
      end else begin
         case (ctl.op)
            OP_LOAD: begin
               cmd_ff <= req_tuser;
               rq_ff  <= req_tdata[15:0];
               mk_ff  <= req_tdata[47:16];
               ck_ff  <= req_tdata[79:48];
               tgt_ff <= req_tdata[95:80];
            end
            OP_LOCK: begin
               if (lk_enq) begin
                  bc_ff[hit_idx] <= hit_bc + QCW'(1);
               end else if (!hit_any && free_any) begin
                  sv_ff[free_idx] <= 1'b1;
                  sk_ff[free_idx] <= lk_key;
                  so_ff[free_idx] <= lk_proc;
                  bc_ff[free_idx] <= '0;
               end
               j_ff <= j_ff + WCW'(1);
            end
            OP_SI_HIT:    si_ff <= hit_idx;
            OP_SI_ZERO:   si_ff <= '0;
            OP_INC_SI:    si_ff <= si_ff + SW'(1);
            OP_GRANT: begin
               so_ff[si_ff] <= fq_rd_ff;
               m_ff         <= '0;
            end
            OP_FREE_SLOT: sv_ff[si_ff] <= 1'b0;
            OP_WR_SHIFT:  m_ff <= mp1;
            OP_DEC_BC:    bc_ff[si_ff] <= bc_ff[si_ff] - QCW'(1);
            OP_K_ZERO:    k_ff <= '0;
            OP_INC_K:     k_ff <= k_ff + QCW'(1);
            OP_MATCH: begin
               found_ff <= 1'b1;
               m_ff     <= k_ff;
            end
            OP_WAIT_ADD: begin
               si_ff <= hit_idx;
               if (cvh_any) begin
                  wl_ff[wt_c][wt_j] <= 1'b1;
                  wc_ff[wt_c]       <= wc_ff[wt_c] + WCW'(1);
               end else begin
                  cvv_ff[wt_c]    <= 1'b1;
                  cvk_ff[wt_c]    <= ck_ff;
                  wl_ff[wt_c]     <= WAITERS_PER_CV'(1);
                  wc_ff[wt_c]     <= WCW'(1);
               end
            end
            OP_CI_HIT: begin
               ci_ff <= cvh_idx;
               j_ff  <= '0;
            end
            OP_CV_ZERO: begin
               ci_ff    <= '0;
               found_ff <= 1'b0;
            end
            OP_INC_CI: ci_ff <= ci_ff + CW'(1);
            OP_J_ZERO: j_ff <= '0;
            OP_INC_J:  j_ff <= j_ff + WCW'(1);
            OP_CANCEL_CMP: begin
               if (wp_rd_ff == tgt_ff) begin
                  wl_ff[ci_ff][j_ff[JW-1:0]] <= 1'b0;
                  found_ff                   <= 1'b1;
               end
               j_ff <= j_ff + WCW'(1);
            end
            OP_FREE_CV: begin
               cvv_ff[ci_ff] <= 1'b0;
               wc_ff[ci_ff]  <= '0;
               wl_ff[ci_ff]  <= '0;
            end
            OP_FREE_CV_DEAD: begin
               if (wl_ff[ci_ff] == '0) begin
                  cvv_ff[ci_ff] <= 1'b0;
                  wc_ff[ci_ff]  <= '0;
               end
            end
            default: found_ff <= found_ff;
         endcase
      end
   end

   // status to controller
   always_comb begin
      st.cmd          = cmd_ff;
      st.mk_hit       = hit_any;
      st.mk_own       = (hit_owner == rq_ff);
      st.ck_hit       = cvh_any;
      st.ck_full      = (wc_ff[cvh_idx] >= WCW'(WAITERS_PER_CV));
      st.cv_free_any  = cvf_any;
      st.si_valid     = sv_ff[si_ff];
      st.si_owner_tgt = (so_ff[si_ff] == tgt_ff);
      st.si_bc_zero   = (bc_ff[si_ff] == '0);
      st.si_last      = (si_ff == SW'(MUTEX_SLOTS - 1));
      st.shift_more   = (mp1 < bc_ff[si_ff]);
      st.k_in         = (k_ff < bc_ff[si_ff]);
      st.rd_match     = (fq_rd_ff == tgt_ff);
      st.ci_valid     = cvv_ff[ci_ff];
      st.ci_last      = (ci_ff == CW'(CV_SLOTS - 1));
      st.j_in         = (j_ff < wc_ff[ci_ff]);
      st.j_live       = wl_ff[ci_ff][j_ff[JW-1:0]];
      st.found        = found_ff;
      st.can_emit     = !hold_v_ff || out_free;
      st.hold_v       = hold_v_ff;
      st.out_free     = out_free;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'b0, out_code_ff, out_dest_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   // a new reply never overruns a word still waiting at the output
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (emit_v && hold_v_ff) |-> out_free)
      else $error("reply pushed while output is full");

   // final word goes out only when the output can take it
   a_flush_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_FLUSH && hold_v_ff) |-> out_free)
      else $error("final reply pushed while output is full");

   // a grant always has a blocked process behind it
   a_grant_queue: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_GRANT) |-> (bc_ff[si_ff] != '0))
      else $error("grant from an empty queue");

   // a waiter is only added by the owner into a list with room
   a_wait_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_WAIT_ADD) |-> (hit_any && (hit_owner == rq_ff) &&
                                   (!cvh_any || wc_ff[cvh_idx] < WCW'(WAITERS_PER_CV))))
      else $error("waiter added without ownership or room");
`endif

endmodule

>>> hdl/mclm_ctrl.sv
module mclm_ctrl import mclm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type st,
   output dp_cmd_type  ctl
);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_DISP      = 5'd1;
   localparam logic [4:0] S_LOCK      = 5'd2;
   localparam logic [4:0] S_EMIT      = 5'd3;
   localparam logic [4:0] S_REL       = 5'd4;
   localparam logic [4:0] S_GRANT     = 5'd5;
   localparam logic [4:0] S_SHIFT     = 5'd6;
   localparam logic [4:0] S_SHIFT_WR  = 5'd7;
   localparam logic [4:0] S_QR        = 5'd8;
   localparam logic [4:0] S_QR_CMP    = 5'd9;
   localparam logic [4:0] S_QR_AFTER  = 5'd10;
   localparam logic [4:0] S_INT_SL    = 5'd11;
   localparam logic [4:0] S_INT_ADV   = 5'd12;
   localparam logic [4:0] S_INT_EMIT  = 5'd13;
   localparam logic [4:0] S_TRM_SL    = 5'd14;
   localparam logic [4:0] S_TRM_Q     = 5'd15;
   localparam logic [4:0] S_TRM_ADV   = 5'd16;
   localparam logic [4:0] S_CVC       = 5'd17;
   localparam logic [4:0] S_CVJ       = 5'd18;
   localparam logic [4:0] S_CV_CMP    = 5'd19;
   localparam logic [4:0] S_CV_END    = 5'd20;
   localparam logic [4:0] S_CV_ADV    = 5'd21;
   localparam logic [4:0] S_BC_J      = 5'd22;
   localparam logic [4:0] S_BC_LK     = 5'd23;
   localparam logic [4:0] S_FLUSH     = 5'd24;

   logic [4:0] state_ff, state_in;
   logic [4:0] rel_ret_ff, rel_ret_in;
   logic [4:0] shf_ret_ff, shf_ret_in;
   logic [2:0] code_ff, code_in;

   assign req_tready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      rel_ret_in = rel_ret_ff;
      shf_ret_in = shf_ret_ff;
      code_in    = code_ff;
      ctl.op     = OP_NOP;
      ctl.code   = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (st.cmd)
               CMD_LOCK: state_in = S_LOCK;
               CMD_UNLOCK: begin
                  if (st.mk_hit && !st.mk_own) begin
                     code_in  = RC_PERM;
                     state_in = S_EMIT;
                  end else if (st.mk_hit) begin
                     ctl.op     = OP_SI_HIT;
                     code_in    = RC_OK;
                     rel_ret_in = S_EMIT;
                     state_in   = S_REL;
                  end else begin
                     code_in  = RC_OK;
                     state_in = S_EMIT;
                  end
               end
               CMD_WAIT: begin
                  if (!(st.mk_hit && st.mk_own)) begin
                     code_in  = RC_INVAL;
                     state_in = S_EMIT;
                  end else if (st.ck_hit ? st.ck_full : !st.cv_free_any) begin
                     code_in  = RC_FULL;
                     state_in = S_EMIT;
                  end else begin
                     ctl.op     = OP_WAIT_ADD;
                     rel_ret_in = S_FLUSH;
                     state_in   = S_REL;
                  end
               end
               CMD_BCAST: begin
                  code_in = RC_OK;
                  if (st.ck_hit) begin
                     ctl.op   = OP_CI_HIT;
                     state_in = S_BC_J;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
               CMD_INTR: begin
                  ctl.op   = OP_SI_ZERO;
                  state_in = S_INT_SL;
               end
               CMD_TERM: begin
                  ctl.op   = OP_SI_ZERO;
                  state_in = S_TRM_SL;
               end
               default: begin
                  code_in  = RC_INVAL;
                  state_in = S_EMIT;
               end
            endcase
         end
         S_LOCK: begin
            if (st.can_emit) begin
               ctl.op   = OP_LOCK;
               state_in = S_FLUSH;
            end
         end
         S_EMIT: begin
            if (st.can_emit) begin
               ctl.op   = OP_EMIT_REQ;
               state_in = S_FLUSH;
            end
         end
         // release of slot si: grant to queue head or free
         S_REL: begin
            if (st.si_bc_zero) begin
               ctl.op   = OP_FREE_SLOT;
               state_in = rel_ret_ff;
            end else begin
               ctl.op   = OP_RD_HEAD;
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            if (st.can_emit) begin
               ctl.op     = OP_GRANT;
               shf_ret_in = rel_ret_ff;
               state_in   = S_SHIFT;
            end
         end
         // close the gap in the queue, reading and then writing one entry at a time
         S_SHIFT: begin
            if (st.shift_more) begin
               ctl.op   = OP_RD_NEXT;
               state_in = S_SHIFT_WR;
            end else begin
               ctl.op   = OP_DEC_BC;
               state_in = shf_ret_ff;
            end
         end
         S_SHIFT_WR: begin
            ctl.op   = OP_WR_SHIFT;
            state_in = S_SHIFT;
         end
         // scan the queue of slot si for the target
         S_QR: begin
            if (st.k_in) begin
               ctl.op   = OP_RD_K;
               state_in = S_QR_CMP;
            end else begin
               state_in = (st.cmd == CMD_INTR) ? S_INT_ADV : S_TRM_ADV;
            end
         end
         S_QR_CMP: begin
            if (st.rd_match) begin
               ctl.op     = OP_MATCH;
               shf_ret_in = S_QR_AFTER;
               state_in   = S_SHIFT;
            end else begin
               ctl.op   = OP_INC_K;
               state_in = S_QR;
            end
         end
         S_QR_AFTER: state_in = (st.cmd == CMD_INTR) ? S_INT_EMIT : S_QR;
         // interrupt walk over slots
         S_INT_SL: begin
            if (st.si_valid) begin
               ctl.op   = OP_K_ZERO;
               state_in = S_QR;
            end else begin
               state_in = S_INT_ADV;
            end
         end
         S_INT_ADV: begin
            if (st.si_last) begin
               ctl.op   = OP_CV_ZERO;
               state_in = S_CVC;
            end else begin
               ctl.op   = OP_INC_SI;
               state_in = S_INT_SL;
            end
         end
         S_INT_EMIT: begin
            if (st.can_emit) begin
               ctl.op   = OP_EMIT_TGT;
               ctl.code = RC_INTR;
               state_in = S_FLUSH;
            end
         end
         // terminate walk over slots
         S_TRM_SL: begin
            if (st.si_valid && st.si_owner_tgt) begin
               rel_ret_in = S_TRM_Q;
               state_in   = S_REL;
            end else begin
               state_in = S_TRM_Q;
            end
         end
         S_TRM_Q: begin
            if (st.si_valid) begin
               ctl.op   = OP_K_ZERO;
               state_in = S_QR;
            end else begin
               state_in = S_TRM_ADV;
            end
         end
         S_TRM_ADV: begin
            if (st.si_last) begin
               ctl.op   = OP_CV_ZERO;
               state_in = S_CVC;
            end else begin
               ctl.op   = OP_INC_SI;
               state_in = S_TRM_SL;
            end
         end
         // cancel the target's waiter entries
         S_CVC: begin
            if (st.ci_valid) begin
               ctl.op   = OP_J_ZERO;
               state_in = S_CVJ;
            end else begin
               state_in = S_CV_ADV;
            end
         end
         S_CVJ: begin
            if (!st.j_in) begin
               state_in = S_CV_END;
            end else if (st.j_live) begin
               ctl.op   = OP_RD_W;
               state_in = S_CV_CMP;
            end else begin
               ctl.op = OP_INC_J;
            end
         end
         S_CV_CMP: begin
            ctl.op   = OP_CANCEL_CMP;
            state_in = S_CVJ;
         end
         S_CV_END: begin
            ctl.op   = OP_FREE_CV_DEAD;
            state_in = S_CV_ADV;
         end
         S_CV_ADV: begin
            if (!st.ci_last) begin
               ctl.op   = OP_INC_CI;
               state_in = S_CVC;
            end else if (st.cmd == CMD_INTR && st.found) begin
               state_in = S_INT_EMIT;
            end else begin
               state_in = S_FLUSH;
            end
         end
         // broadcast: each live waiter relocks its mutex
         S_BC_J: begin
            if (!st.j_in) begin
               ctl.op   = OP_FREE_CV;
               state_in = S_EMIT;
            end else if (st.j_live) begin
               ctl.op   = OP_RD_W;
               state_in = S_BC_LK;
            end else begin
               ctl.op = OP_INC_J;
            end
         end
         S_BC_LK: begin
            if (st.can_emit) begin
               ctl.op   = OP_LOCK;
               state_in = S_BC_J;
            end
         end
         // mark the last word and hand it out
         S_FLUSH: begin
            if (!st.hold_v) begin
               state_in = S_IDLE;
            end else if (st.out_free) begin
               ctl.op   = OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rel_ret_ff <= S_FLUSH;
         shf_ret_ff <= S_FLUSH;
         code_ff    <= RC_OK;
      end else begin
         state_ff   <= state_in;
         rel_ret_ff <= rel_ret_in;
         shf_ret_ff <= shf_ret_in;
         code_ff    <= code_in;
      end
   end

endmodule

>>> hdl/mutex_condvar_lock_manager_unit.sv
// steps: lock, bad commands and unlock of a free key go load, dispatch, reply, flush
// unlock that frees its slot adds a slot release; one that grants also shifts its queue
// interrupt and terminate walk every slot queue and waiter list
// throughput: one request at a time, set by the sequencer's walk over queue and waiter memory
// reset: synchronous active high, empties all tables at once, no clearing pass
module mutex_condvar_lock_manager_unit import mclm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // requester, mutex_key, condvar_key, target_process
   input  logic [2:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // dest_process, reply_code, zero pad
   output logic        rsp_tlast
);

   dp_cmd_type  ctl;
   dp_stat_type st;

   // sequencer
   mclm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .ctl        (ctl)
   );

   // tables, memories and reply staging
   mclm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctl        (ctl),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
